[rtl/core/rte_pkg.sv]
`timescale 1ns / 1ps

package rte_pkg;

  // configuration register width and register indexes
  localparam int CFG_BITS = 16;
  localparam logic REG_DEBOUNCE_MS   = 1'b0;
  localparam logic REG_LONG_PRESS_MS = 1'b1;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_MS_RESET   = 16'd20;
  localparam logic [CFG_BITS-1:0] LONG_PRESS_MS_RESET = 16'd800;

  // direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // quadrature step codes
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef struct packed {
    logic               pin_a;
    logic               pin_b;
    logic               button_level;
    logic               ms_tick;
    logic               load_count;
    logic signed [31:0] load_value;
    logic               clear_events;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [1:0]         direction;
    logic               short_press;
    logic               long_press;
    logic               button_stable;
  } out_item_t;

  // button status reported by the debounce unit
  typedef struct packed {
    logic stable;
    logic short_flag;
    logic long_flag;
  } btn_status_t;

  // quadrature table, index is old ab and new ab
  function automatic step_t quad_step(input logic [1:0] old_ab, input logic [1:0] new_ab);
    step_t s;
    unique case ({old_ab, new_ab})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_UP;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_DOWN;
      default:                            s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/rte_encoder.sv]
`timescale 1ns / 1ps

module rte_encoder #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               primed,
  input  logic [1:0]         ab,
  input  logic               load_count,
  input  logic signed [31:0] load_value,
  input  logic               clear_events,
  output logic signed [31:0] position,
  output logic [1:0]         direction
);
  import rte_pkg::*;

  logic [1:0]            previous_ab, previous_ab_next;
  logic [COUNT_BITS-1:0] step_count, step_count_next;
  logic [1:0]            last_direction, dir_next;
  step_t                 step;

  // table lookup and count update
  always_comb begin
    step             = quad_step(previous_ab, ab);
    previous_ab_next = previous_ab;
    step_count_next  = step_count;
    dir_next         = last_direction;
    if (!primed) begin
      previous_ab_next = ab;
    end else if (ab != previous_ab) begin
      previous_ab_next = ab;
      unique case (step)
        STEP_UP: begin
          step_count_next = step_count + COUNT_BITS'(1);
          dir_next        = DIR_CW;
        end
        STEP_DOWN: begin
          step_count_next = step_count - COUNT_BITS'(1);
          dir_next        = DIR_CCW;
        end
        default: ;
      endcase
    end
    // a load wins over the step
    if (load_count) begin
      step_count_next = COUNT_BITS'(load_value);
    end
  end

  assign position  = $signed(32'(step_count_next));
  assign direction = dir_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_ab    <= 2'b00;
      step_count     <= '0;
      last_direction <= DIR_NONE;
    end else if (en) begin
      previous_ab    <= previous_ab_next;
      step_count     <= step_count_next;
      last_direction <= clear_events ? DIR_NONE : dir_next;
    end
  end

endmodule

[rtl/core/rte_button.sv]
`timescale 1ns / 1ps

module rte_button #(
  parameter int TIMER_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         primed,
  input  logic                         button_level,
  input  logic                         ms_tick,
  input  logic                         clear_events,
  input  logic [rte_pkg::CFG_BITS-1:0] debounce_ms,
  input  logic [rte_pkg::CFG_BITS-1:0] long_press_ms,
  output rte_pkg::btn_status_t         status
);
  import rte_pkg::*;

  localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  logic                  stable_level, stable_next;
  logic                  debounce_active, active_next;
  logic [TIMER_BITS-1:0] debounce_elapsed, deb_tick, deb_next;
  logic [TIMER_BITS-1:0] held_elapsed, held_tick, held_next;
  logic                  short_flag, short_next;
  logic                  long_flag, long_next;
  logic                  deb_done, held_long;

  // saturating millisecond timers
  always_comb begin
    held_tick = held_elapsed;
    deb_tick  = debounce_elapsed;
    if (ms_tick) begin
      if (held_elapsed != '1) held_tick = held_elapsed + TIMER_BITS'(1);
      if (debounce_active && debounce_elapsed != '1) begin
        deb_tick = debounce_elapsed + TIMER_BITS'(1);
      end
    end
  end

  assign deb_done  = CMP_BITS'(deb_tick)  >= CMP_BITS'(debounce_ms);
  assign held_long = CMP_BITS'(held_tick) >= CMP_BITS'(long_press_ms);

  // debounce start, expiry and press classification
  always_comb begin
    stable_next = stable_level;
    active_next = debounce_active;
    deb_next    = deb_tick;
    held_next   = held_tick;
    short_next  = short_flag;
    long_next   = long_flag;
    if (!primed) begin
      stable_next = button_level;
    end else if (debounce_active) begin
      if (deb_done) begin
        active_next = 1'b0;
        if (button_level != stable_level) begin
          stable_next = button_level;
          if (!button_level) begin
            held_next = '0;
          end else if (held_long) begin
            long_next = 1'b1;
          end else begin
            short_next = 1'b1;
          end
        end
      end
    end else if (button_level != stable_level) begin
      active_next = 1'b1;
      deb_next    = '0;
    end
  end

  assign status = '{stable: stable_next, short_flag: short_next, long_flag: long_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level     <= 1'b1;
      debounce_active  <= 1'b0;
      debounce_elapsed <= '0;
      held_elapsed     <= '0;
      short_flag       <= 1'b0;
      long_flag        <= 1'b0;
    end else if (en) begin
      stable_level     <= stable_next;
      debounce_active  <= active_next;
      debounce_elapsed <= deb_next;
      held_elapsed     <= held_next;
      short_flag       <= short_next && !clear_events;
      long_flag        <= long_next && !clear_events;
    end
  end

endmodule

[rtl/core/rotary_encoder_with_button.sv]
`timescale 1ns / 1ps

// channel    | handshake            | payload
// -----------+----------------------+------------------------------
// input      | in_valid / in_ready  | in_item  (rte_pkg::in_item_t)
// output     | out_valid / out_ready| out_item (rte_pkg::out_item_t)
// config     | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// one item per cycle sustained while out_ready is high; a request accepted into the
// input register is decoded there and its result is captured in the result
// register, from which it leaves.
// the whole state update is done in the cycle the item leaves the input register.
// synchronous reset, no clearing pass; stalls on the output hold both registers
// and drop in_ready only when both are full and out_ready is low.

module rotary_encoder_with_button #(
  parameter int COUNT_BITS = 32,
  parameter int TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rte_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output rte_pkg::out_item_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rte_pkg::*;

  logic [CFG_BITS-1:0] debounce_ms_reg, long_press_ms_reg;
  logic                s1_valid;
  in_item_t            s1_item;
  logic                advance, commit;
  logic                primed;
  logic signed [31:0]  position;
  logic [1:0]          direction;
  btn_status_t         status;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms_reg   <= DEBOUNCE_MS_RESET;
      long_press_ms_reg <= LONG_PRESS_MS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DEBOUNCE_MS:   debounce_ms_reg   <= pwdata[CFG_BITS-1:0];
        REG_LONG_PRESS_MS: long_press_ms_reg <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE_MS:   prdata = 32'(debounce_ms_reg);
      REG_LONG_PRESS_MS: prdata = 32'(long_press_ms_reg);
      default:           prdata = '0;
    endcase
  end

  // request flow: input register, then result register
  assign advance  = !out_valid || out_ready;
  assign commit   = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item <= in_item;
  end

  // first request captures the pins instead of decoding a step or press
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (commit) begin
      primed <= 1'b1;
    end
  end

  rte_encoder #(
    .COUNT_BITS(COUNT_BITS)
  ) u_encoder (
    .clk         (clk),
    .rst         (rst),
    .en          (commit),
    .primed      (primed),
    .ab          ({s1_item.pin_a, s1_item.pin_b}),
    .load_count  (s1_item.load_count),
    .load_value  (s1_item.load_value),
    .clear_events(s1_item.clear_events),
    .position    (position),
    .direction   (direction)
  );

  rte_button #(
    .TIMER_BITS(TIMER_BITS)
  ) u_button (
    .clk          (clk),
    .rst          (rst),
    .en           (commit),
    .primed       (primed),
    .button_level (s1_item.button_level),
    .ms_tick      (s1_item.ms_tick),
    .clear_events (s1_item.clear_events),
    .debounce_ms  (debounce_ms_reg),
    .long_press_ms(long_press_ms_reg),
    .status       (status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_item.position      <= position;
      out_item.direction     <= direction;
      out_item.short_press   <= status.short_flag;
      out_item.long_press    <= status.long_flag;
      out_item.button_stable <= status.stable;
    end
  end

  // checks
  a_primed_after_commit: assert property (@(posedge clk) disable iff (rst)
    commit |=> primed)
    else $error("primed not set after first request");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled while a stage is free");

  a_direction_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.direction != 2'd3))
    else $error("invalid direction code");

endmodule
